// ===== rtl/dtt_pkg.sv =====
package dtt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 48;

    localparam int REQ_BITS   = 3;
    localparam int FIELD_TIME = 48;
    localparam int SLOT_BITS  = 4;

    localparam logic [REQ_BITS-1:0] REQ_ADD     = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_CANCEL  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_REFRESH = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_RESET   = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_SCAN    = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic [REQ_BITS-1:0]   req_type;
        logic [FIELD_TIME-1:0] now_time;
        logic [SLOT_BITS-1:0]  slot_id;
        logic [FIELD_TIME-1:0] period_ms;
        logic                  repeats;
    } dtt_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  result_slot;
        logic [FIELD_TIME-1:0] remaining;
        logic                  front_notice;
        logic                  last;
    } dtt_rsp_t;

endpackage

// ===== rtl/deadline_timer_table_unit.sv =====
// Deadline timer table: NUM_TIMERS one-shot or recurring timer slots.
// Request channel: a request item is taken on a clock edge with start high
// and busy low. Busy rises the next cycle and falls in the cycle that shows
// the final result item. Unknown request types are dropped: no result.
// Result channel: each result item is on result for one cycle, marked by
// done; result.last flags the final item of a request. The receiver cannot
// stall, so results are never held back.
// Passes: each pass sweeps the slot memory one slot a cycle (NUM_TIMERS
// reads through the single read port) to find the earliest active slot and
// the earliest due slot not yet emitted. Add, cancel, refresh and query show
// their result after one pass; a new item can be taken only once busy is
// low again. Reset runs a second pass with the new deadline in place before
// its result is shown.
// A scan runs one pass per expired slot plus a final one, unless all
// NUM_TIMERS slots expire; each expired slot is shown after the following
// pass, once it is known whether it is last.
// Active and recurring bits live in flip-flops cleared by reset; periods
// and deadlines live in one synchronous memory written only by requests,
// so reset needs no clearing pass. The notice-pending flag resets to 0.
module deadline_timer_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dtt_pkg::dtt_req_t req,
    output logic              busy,
    output logic              done,
    output dtt_pkg::dtt_rsp_t result
);
    import dtt_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;

    // period and deadline packed in one memory word
    logic [2*TIME_BITS-1:0] mem [NUM_TIMERS];
    logic [2*TIME_BITS-1:0] rd_data;
    logic [IW-1:0]          rd_addr;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [2*TIME_BITS-1:0] wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    logic [NUM_TIMERS-1:0] act_reg, act_next;
    logic [NUM_TIMERS-1:0] rep_reg, rep_next;
    logic [NUM_TIMERS-1:0] taken_reg, taken_next;
    logic                  notice_reg, notice_next;
    logic [2:0]            state_reg, state_next;
    dtt_req_t              req_reg, req_next;
    logic [CW-1:0]         cnt_reg, cnt_next;     // address issued
    logic [IW-1:0]         rix_reg, rix_next;     // index of data returning
    logic                  rv_reg, rv_next;       // read data valid
    // earliest active
    logic                  e_ok_reg, e_ok_next;
    logic [IW-1:0]         e_ix_reg, e_ix_next;
    logic [TIME_BITS-1:0]  e_dl_reg, e_dl_next;
    // earliest due not taken
    logic                  d_ok_reg, d_ok_next;
    logic [IW-1:0]         d_ix_reg, d_ix_next;
    logic [TIME_BITS-1:0]  d_dl_reg, d_dl_next;
    logic [TIME_BITS-1:0]  d_per_reg, d_per_next;
    logic [TIME_BITS-1:0]  s_per_reg, s_per_next; // period of req slot
    logic [CW-1:0]         nout_reg, nout_next;
    logic                  done_reg, done_next;
    dtt_rsp_t              rsp_reg, rsp_next;
    // scan: slot taken but not yet shown
    logic [SLOT_BITS-1:0]  pend_reg, pend_next;

    logic [TIME_BITS-1:0]  now_t, per_t, cur_per, cur_dl;
    logic [TIME_BITS:0]    sum_w;
    logic [TIME_BITS-1:0]  sat_dl;
    logic                  sid_ok;
    logic [IW-1:0]         sid;
    logic                  free_ok;
    logic [IW-1:0]         free_ix;

    assign now_t   = req_reg.now_time[TIME_BITS-1:0];
    assign per_t   = req_reg.period_ms[TIME_BITS-1:0];
    assign cur_per = rd_data[2*TIME_BITS-1:TIME_BITS];
    assign cur_dl  = rd_data[TIME_BITS-1:0];
    assign sid_ok  = ({1'b0, req_reg.slot_id} < (SLOT_BITS+1)'(NUM_TIMERS))
                     && act_reg[IW'(req_reg.slot_id)];
    assign sid     = IW'(req_reg.slot_id);

    always_comb
    begin
        free_ok = 1'b0;
        free_ix = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!act_reg[i])
            begin
                free_ok = 1'b1;
                free_ix = IW'(i);
            end
        end
    end

    // saturating add; operand depends on request
    logic [TIME_BITS-1:0] add_b;
    always_comb
    begin
        priority case (1'b1)
            req_reg.req_type == REQ_REFRESH: add_b = s_per_reg;
            req_reg.req_type == REQ_SCAN:    add_b = d_per_reg;
            default:                         add_b = per_t;
        endcase
        sum_w  = {1'b0, now_t} + {1'b0, add_b};
        sat_dl = sum_w[TIME_BITS] ? TMAX : sum_w[TIME_BITS-1:0];
    end

    logic [IW-1:0] tgt;
    logic [IW-1:0] earliest_ix;

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        cnt_next    = cnt_reg;
        rix_next    = rix_reg;
        rv_next     = 1'b0;
        act_next    = act_reg;
        rep_next    = rep_reg;
        taken_next  = taken_reg;
        notice_next = notice_reg;
        e_ok_next   = e_ok_reg;
        e_ix_next   = e_ix_reg;
        e_dl_next   = e_dl_reg;
        d_ok_next   = d_ok_reg;
        d_ix_next   = d_ix_reg;
        d_dl_next   = d_dl_reg;
        d_per_next  = d_per_reg;
        s_per_next  = s_per_reg;
        nout_next   = nout_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        pend_next   = pend_reg;
        rd_addr     = cnt_reg[IW-1:0];
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        tgt         = '0;
        earliest_ix = '0;

        // fold returning read into the running minimums
        if (rv_reg && act_reg[rix_reg])
        begin
            if (!e_ok_reg || cur_dl < e_dl_reg)
            begin
                e_ok_next = 1'b1;
                e_ix_next = rix_reg;
                e_dl_next = cur_dl;
            end
            if (!taken_reg[rix_reg] && cur_dl <= now_t
                && (!d_ok_reg || cur_dl < d_dl_reg))
            begin
                d_ok_next  = 1'b1;
                d_ix_next  = rix_reg;
                d_dl_next  = cur_dl;
                d_per_next = cur_per;
            end
            if (rix_reg == sid)
            begin
                s_per_next = cur_per;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    taken_next = '0;
                    nout_next  = '0;
                    cnt_next   = '0;
                    e_ok_next  = 1'b0;
                    d_ok_next  = 1'b0;
                    state_next = (req.req_type > REQ_QUERY) ? S_IDLE : S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                rv_next  = 1'b1;
                rix_next = cnt_reg[IW-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NUM_TIMERS - 1))
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                done_next = 1'b1;
                rsp_next  = '0;
                rsp_next.last = 1'b1;
                state_next = S_IDLE;
                unique case (req_reg.req_type)
                    REQ_ADD:
                    begin
                        if (!free_ok)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            tgt = free_ix;
                            act_next[tgt] = 1'b1;
                            rep_next[tgt] = req_reg.repeats;
                            wr_en   = 1'b1;
                            wr_addr = tgt;
                            wr_data = {per_t, sat_dl};
                            rsp_next.result_slot = SLOT_BITS'(tgt);
                            earliest_ix = tgt;
                            if (e_ok_reg && (e_dl_reg < sat_dl
                                || (e_dl_reg == sat_dl && e_ix_reg < tgt)))
                            begin
                                earliest_ix = e_ix_reg;
                            end
                            if (earliest_ix == tgt && !notice_reg)
                            begin
                                notice_next = 1'b1;
                                rsp_next.front_notice = 1'b1;
                            end
                        end
                    end
                    REQ_CANCEL, REQ_REFRESH, REQ_RESET:
                    begin
                        if (!sid_ok)
                        begin
                            rsp_next.status = ST_INACTIVE;
                        end
                        else if (req_reg.req_type == REQ_CANCEL)
                        begin
                            act_next[sid] = 1'b0;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = sid;
                            if (req_reg.req_type == REQ_REFRESH)
                            begin
                                wr_data = {s_per_reg, sat_dl};
                            end
                            else
                            begin
                                wr_data = {per_t, sat_dl};
                                // earliest among others: needs fresh sweep,
                                // so rescan with the new deadline in place
                                done_next  = 1'b0;
                                state_next = S_WR;
                            end
                        end
                    end
                    REQ_SCAN:
                    begin
                        if (!d_ok_reg)
                        begin
                            if (nout_reg == '0)
                            begin
                                rsp_next.status = ST_NONE;
                            end
                            else
                            begin
                                // held item turns out to be the last
                                rsp_next.result_slot = pend_reg;
                            end
                        end
                        else
                        begin
                            // hold output until next sweep tells if last
                            done_next = 1'b0;
                            tgt = d_ix_reg;
                            taken_next[tgt] = 1'b1;
                            if (rep_reg[tgt])
                            begin
                                wr_en   = 1'b1;
                                wr_addr = tgt;
                                wr_data = {d_per_reg, sat_dl};
                            end
                            else
                            begin
                                act_next[tgt] = 1'b0;
                            end
                            // flush previous pending item as not last
                            if (nout_reg != '0)
                            begin
                                done_next = 1'b1;
                                rsp_next.result_slot = pend_reg;
                                rsp_next.last = 1'b0;
                            end
                            pend_next  = SLOT_BITS'(d_ix_reg);
                            nout_next  = nout_reg + 1'b1;
                            cnt_next   = '0;
                            e_ok_next  = 1'b0;
                            d_ok_next  = 1'b0;
                            state_next = (nout_reg == CW'(NUM_TIMERS - 1))
                                         ? S_WR : S_SWEEP;
                        end
                    end
                    REQ_QUERY:
                    begin
                        notice_next = 1'b0;
                        if (!e_ok_reg)
                        begin
                            rsp_next.status    = ST_NONE;
                            rsp_next.remaining = '1;
                        end
                        else if (now_t < e_dl_reg)
                        begin
                            rsp_next.remaining = FIELD_TIME'(e_dl_reg - now_t);
                        end
                    end
                    default:
                    begin
                        done_next = 1'b0;
                    end
                endcase
            end
            S_WR:
            begin
                // end of a full scan, or start of the second pass of reset
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '0;
                rsp_next.last = 1'b1;
                if (req_reg.req_type == REQ_SCAN)
                begin
                    rsp_next.result_slot = pend_reg;
                end
                else
                begin
                    req_next.req_type = REQ_QUERY; // marks second pass
                    state_next = S_SWEEP;
                    cnt_next   = '0;
                    e_ok_next  = 1'b0;
                    done_next  = 1'b0;
                    nout_next  = CW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // reset second pass: compare winner with slot
        if (state_reg == S_EXEC && req_reg.req_type == REQ_QUERY
            && nout_reg == CW'(1))
        begin
            notice_next = notice_reg;
            rsp_next = '0;
            rsp_next.last = 1'b1;
            if (e_ix_reg == IW'(req_reg.slot_id) && !notice_reg)
            begin
                notice_next = 1'b1;
                rsp_next.front_notice = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= '0;
            rep_reg    <= '0;
            notice_reg <= 1'b0;
            done_reg   <= 1'b0;
            rv_reg     <= 1'b0;
            cnt_reg    <= '0;
            nout_reg   <= '0;
            e_ok_reg   <= 1'b0;
            d_ok_reg   <= 1'b0;
            taken_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            rep_reg    <= rep_next;
            notice_reg <= notice_next;
            done_reg   <= done_next;
            rv_reg     <= rv_next;
            cnt_reg    <= cnt_next;
            nout_reg   <= nout_next;
            e_ok_reg   <= e_ok_next;
            d_ok_reg   <= d_ok_next;
            taken_reg  <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rix_reg   <= rix_next;
        e_ix_reg  <= e_ix_next;
        e_dl_reg  <= e_dl_next;
        d_ix_reg  <= d_ix_next;
        d_dl_reg  <= d_dl_next;
        d_per_reg <= d_per_next;
        s_per_reg <= s_per_next;
        rsp_reg   <= rsp_next;
        pend_reg  <= pend_next;
    end

    assign result = rsp_reg;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;

    a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.req_type <= REQ_QUERY) |=> busy)
        else $error("request not taken");
    a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (cnt_reg < CW'(NUM_TIMERS)))
        else $error("sweep address out of range");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.last && req_reg.req_type != REQ_SCAN) |-> $past(busy))
        else $error("result without request");
endmodule
